[hw/rtl/sha512_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-512 block hash package
// Payload types, round constants, initial hash values and a rotate function.
// ----------------------------------------------------------------------------
package sha512_pkg;

   typedef struct packed {
      logic [63:0] msg_word;
      logic        starts_message;
      logic        ends_message;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  digest_index;
      logic        is_final;
   } rsp_type;

   // One queued word, already classified by the front end.
   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  slot;
      logic        restart;
      logic        compress;
      logic        emit;
   } fwd_type;

   localparam int QueueDepth = 4;
   localparam int Rounds     = 80;

   function automatic logic [63:0] init_hash(input logic [2:0] i);
      logic [63:0] r;
      unique case (i)
         3'd0: r = 64'h6a09e667f3bcc908;
         3'd1: r = 64'hbb67ae8584caa73b;
         3'd2: r = 64'h3c6ef372fe94f82b;
         3'd3: r = 64'ha54ff53a5f1d36f1;
         3'd4: r = 64'h510e527fade682d1;
         3'd5: r = 64'h9b05688c2b3e6c1f;
         3'd6: r = 64'h1f83d9abfb41bd6b;
         default: r = 64'h5be0cd19137e2179;
      endcase
      return r;
   endfunction

   localparam logic [63:0] RoundK [Rounds] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   function automatic logic [63:0] rotr(input logic [63:0] v, input int r);
      return (v >> r) | (v << (64 - r));
   endfunction

endpackage

[hw/rtl/sha512_front.sv]
// ----------------------------------------------------------------------------
// SHA-512 front end
// Tracks block alignment, classifies each word and queues it for the core.
// ----------------------------------------------------------------------------
module sha512_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sha512_pkg::req_type req_data,
   output logic                fwd_valid,
   input  logic                fwd_take,
   output sha512_pkg::fwd_type fwd_data
);
   import sha512_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   fwd_type          queue_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]    count_ff, count_in;
   logic [3:0]       word_count_ff, word_count_in;
   logic [3:0]       slot;
   logic             push, pop;
   fwd_type          entry;

   assign req_stall = (count_ff == (PtrW+1)'(QueueDepth));
   assign push      = req_valid && !req_stall;
   assign pop       = fwd_take && (count_ff != '0);
   assign fwd_valid = (count_ff != '0);
   assign fwd_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      slot           = req_data.starts_message ? 4'd0 : word_count_ff;
      entry.word     = req_data.msg_word;
      entry.slot     = slot;
      entry.restart  = req_data.starts_message;
      entry.compress = (slot == 4'd15);
      entry.emit     = (slot == 4'd15) && req_data.ends_message;
      word_count_in  = push ? slot + 4'd1 : word_count_ff;
      wr_ptr_in      = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in      = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in       = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
      if (reset) begin
         word_count_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         word_count_ff <= word_count_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

endmodule

[hw/rtl/sha512_core.sv]
// ----------------------------------------------------------------------------
// SHA-512 compression core
// Loads words into the schedule window, runs 80 rounds one per cycle,
// folds into the chaining hash and, at a message end, streams out the digest.
// ----------------------------------------------------------------------------
module sha512_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fwd_valid,
   output logic                fwd_take,
   input  sha512_pkg::fwd_type fwd_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sha512_pkg::rsp_type rsp_data,
   output logic                busy
);
   import sha512_pkg::*;

   localparam logic [1:0] StLoad = 2'd0;
   localparam logic [1:0] StRound = 2'd1;
   localparam logic [1:0] StFold = 2'd2;
   localparam logic [1:0] StEmit = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [63:0] hash_ff [8];
   logic [63:0] win_ff [16];
   logic [63:0] v_ff [8];
   logic [6:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        emit_ff;
   logic [3:0]  sl;
   logic [63:0] w15, w2, w7, s0, s1, w, t1, t2, e, a;
   logic        out_free;

   assign out_free = !rsp_valid || !rsp_stall;
   assign fwd_take = (state_ff == StLoad) && fwd_valid;
   assign busy     = (state_ff != StLoad);

   always_comb begin
      sl  = round_ff[3:0];
      w15 = win_ff[sl + 4'd1];
      w2  = win_ff[sl + 4'd14];
      w7  = win_ff[sl + 4'd9];
      s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
      s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
      w   = (round_ff < 7'd16) ? win_ff[sl] : win_ff[sl] + s0 + w7 + s1;
      e   = v_ff[4];
      a   = v_ff[0];
      t1  = v_ff[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
            + ((e & v_ff[5]) ^ (~e & v_ff[6])) + RoundK[round_ff] + w;
      t2  = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
            + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      state_in = state_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         StLoad: begin
            if (fwd_take && fwd_data.compress) begin
               state_in = StRound;
               round_in = '0;
            end
         end
         StRound: begin
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(Rounds - 1)) begin
               state_in = StFold;
               round_in = '0;
            end
         end
         StFold: begin
            idx_in   = '0;
            state_in = emit_ff ? StEmit : StLoad;
         end
         default: begin
            if (out_free) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in = StLoad;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (fwd_take) begin
         win_ff[fwd_data.slot] <= fwd_data.word;
         emit_ff <= fwd_data.emit;
      end
      if (state_ff == StRound) begin
         win_ff[sl] <= w;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
      if (state_ff == StEmit && out_free) begin
         rsp_data.digest_word  <= hash_ff[idx_ff];
         rsp_data.digest_index <= idx_ff;
         rsp_data.is_final     <= (idx_ff == 3'd7);
      end
      if (reset) begin
         state_ff  <= StLoad;
         round_ff  <= '0;
         idx_ff    <= '0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= init_hash(3'(i));
         end
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         if (out_free) begin
            rsp_valid <= (state_ff == StEmit);
         end
         if (fwd_take && fwd_data.restart) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= init_hash(3'(i));
            end
         end
         if (fwd_take && fwd_data.compress) begin
            // working vars start from the chain (restart already applied)
            for (int i = 0; i < 8; i++) begin
               v_ff[i] <= fwd_data.restart ? init_hash(3'(i)) : hash_ff[i];
            end
         end
         if (state_ff == StFold) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= hash_ff[i] + v_ff[i];
            end
         end
      end
   end

endmodule

[hw/rtl/sha512_block_hash_unit.sv]
// ----------------------------------------------------------------------------
// SHA-512 block hash unit
// Padded 1024-bit blocks in as 64-bit words, 512-bit digest out as 8 words.
// ----------------------------------------------------------------------------
// Flow: a block's 16th word passes through the queue, the load state, the 80
// round steps and the fold state; the first digest word is then registered,
// and the rest follow at one per cycle while the receiver does not stall.
// The core loads one word per cycle while words are queued, but takes no new
// word while it runs the rounds, folds or emits a digest.
// Reset: synchronous; chaining hash loads the initial values, queue empties.
module sha512_block_hash_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sha512_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sha512_pkg::rsp_type rsp_data
);
   import sha512_pkg::*;

   logic    fwd_valid, fwd_take, busy;
   fwd_type fwd_data;

   sha512_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .fwd_valid, .fwd_take, .fwd_data
   );

   sha512_core u_core (
      .clock, .reset, .fwd_valid, .fwd_take, .fwd_data,
      .rsp_valid, .rsp_stall, .rsp_data, .busy
   );

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      fwd_take |-> !busy) else $error("core took a word while busy");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      fwd_take |-> fwd_valid) else $error("take without queued word");
   a_final_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_final |-> rsp_data.digest_index == 3'd7)
      else $error("final flag on wrong index");

endmodule

[verif/sha512_block_hash_unit_test.sv]
// ----------------------------------------------------------------------------
// SHA-512 block hash unit testbench
// Feeds padded message words, predicts digests with a local SHA-512 model
// and checks each digest word transfer in order.
// ----------------------------------------------------------------------------
module sha512_block_hash_unit_test;
   import sha512_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   sha512_block_hash_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   localparam logic [63:0] IvWords [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };
   localparam logic [63:0] K [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   // hash model state
   logic [63:0] hash_state [8];
   logic [63:0] block_words [16];
   logic [3:0]  word_pos;

   req_type     pending_words [$];
   rsp_type     digest_queue [$];
   int          errors = 0;
   int          cycle_count = 0;
   bit          stim_done = 1'b0;
   bit          hold_sender = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;

   function automatic logic [63:0] ror(input logic [63:0] v, input int r);
      return (v >> r) | (v << (64 - r));
   endfunction

   task automatic compress_block();
      logic [63:0] w [16];
      logic [63:0] v [8];
      logic [63:0] t1, t2, s0, s1;
      int          r, s;
      w = block_words;
      v = hash_state;
      for (r = 0; r < 80; r++) begin
         s = r % 16;
         if (r >= 16) begin
            s0 = ror(w[(r - 15) % 16], 1) ^ ror(w[(r - 15) % 16], 8) ^ (w[(r - 15) % 16] >> 7);
            s1 = ror(w[(r - 2) % 16], 19) ^ ror(w[(r - 2) % 16], 61) ^ (w[(r - 2) % 16] >> 6);
            w[s] = w[s] + s0 + w[(r - 7) % 16] + s1;
         end
         t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[r] + w[s];
         t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (r = 0; r < 8; r++) hash_state[r] = hash_state[r] + v[r];
   endtask

   task automatic predict_digest(input req_type item);
      rsp_type d;
      if (item.starts_message) begin
         hash_state = IvWords;
         word_pos = '0;
      end
      block_words[word_pos] = item.msg_word;
      word_pos = word_pos + 4'd1;
      if (word_pos == 4'd0) begin
         compress_block();
         if (item.ends_message) begin
            for (int i = 0; i < 8; i++) begin
               d.digest_word  = hash_state[i];
               d.digest_index = 3'(i);
               d.is_final     = (i == 7);
               digest_queue.push_back(d);
            end
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!(req_valid && req_stall)) begin
            if (req_valid) predict_digest(req_data);
            if (gap_left > 0) gap_left = gap_left - 1;
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (pending_words.size() > 0 && !hold_sender && gap_left == 0) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
               burst_left = burst_left - 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern and result check
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest word %h idx %0d final %0b", $time,
                        rsp_data.digest_word, rsp_data.digest_index, rsp_data.is_final);
               errors = errors + 1;
            end else begin
               rsp_type e;
               e = digest_queue.pop_front();
               if (e.digest_word !== rsp_data.digest_word)
                  $display("%0t: digest_word expected %h actual %h", $time,
                           e.digest_word, rsp_data.digest_word);
               if (e.digest_index !== rsp_data.digest_index)
                  $display("%0t: digest_index expected %0d actual %0d", $time,
                           e.digest_index, rsp_data.digest_index);
               if (e.is_final !== rsp_data.is_final)
                  $display("%0t: is_final expected %0b actual %0b", $time,
                           e.is_final, rsp_data.is_final);
               if (e !== rsp_data) errors = errors + 1;
            end
         end
         case ((cycle_count / 500) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ((cycle_count % 7) < 5);
         endcase
      end
   end

   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: w = '0;
         1: w = '1;
         default: ;
      endcase
      return w;
   endfunction

   task automatic add_word(input logic [63:0] w, input bit st, input bit en);
      req_type it;
      it.msg_word = w;
      it.starts_message = st;
      it.ends_message = en;
      pending_words.push_back(it);
   endtask

   // one well-formed message of nblk blocks
   task automatic add_message(input int nblk, input bit first);
      for (int b = 0; b < nblk; b++)
         for (int i = 0; i < 16; i++)
            add_word(rand_word(), first && b == 0 && i == 0, (b == nblk - 1) && i == 15);
   endtask

   initial begin
      int queued;
      hash_state = IvWords;
      word_pos = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: all-zero then all-ones block, each a full message
      for (int i = 0; i < 16; i++) add_word('0, i == 0, i == 15);
      for (int i = 0; i < 16; i++) add_word('1, i == 0, i == 15);
      // partial block dropped by a mid-block start, end mark off a block boundary
      for (int i = 0; i < 5; i++) add_word(rand_word(), i == 0, i == 3);
      add_message(1, 1'b1);
      // continue chaining after digest without a start mark
      add_message(1, 1'b0);

      wait (pending_words.size() == 0 && !req_valid && digest_queue.size() == 0);
      // hold the sender until every digest word is back
      hold_sender = 1'b1;
      add_message(2, 1'b1);
      wait (digest_queue.size() == 0);
      repeat (20) @(posedge clock);
      hold_sender = 1'b0;

      queued = 0;
      while (queued < 330) begin
         case ($urandom_range(0, 9))
            0: begin
               int n;
               n = $urandom_range(1, 20);
               for (int i = 0; i < n; i++)
                  add_word(rand_word(), $urandom_range(0, 15) == 0, $urandom_range(0, 1));
               queued = queued + n;
            end
            1: begin
               add_message(1, 1'b0);
               queued = queued + 16;
            end
            default: begin
               int nb;
               nb = $urandom_range(1, 3);
               add_message(nb, 1'b1);
               queued = queued + 16 * nb;
            end
         endcase
      end
      // flush: a closing message realigns so no digest is left pending
      add_message(1, 1'b1);
      wait (pending_words.size() == 0 && !req_valid);
      wait (digest_queue.size() == 0);
      repeat (200) @(posedge clock);
      stim_done = 1'b1;
   end

   always @(posedge clock) begin
      if (stim_done) begin
         if (errors == 0 && digest_queue.size() == 0)
            $display("Testbench completed without errors");
         else
            $display("Testbench completed WITH ERRORS");
         $finish;
      end else if (cycle_count > 600000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

[sim.f]
hw/rtl/sha512_pkg.sv
hw/rtl/sha512_front.sv
hw/rtl/sha512_core.sv
hw/rtl/sha512_block_hash_unit.sv
verif/sha512_block_hash_unit_test.sv
